@@ rtl/skl_pkg.sv @@
// Shared types and constants of the sorted key to id lookup block.
package skl_pkg;

  localparam int unsigned IdxW      = 10;
  localparam int unsigned KeyW      = 64;
  localparam int unsigned DocCountW = 11;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  // Value of paddr[2] that selects the document count register.
  localparam logic RegDocCount = 1'b0;

  typedef enum logic [1:0] {
    MODE_WRITE_KEY  = 2'd0,
    MODE_LOAD_ORDER = 2'd1,
    MODE_FIND       = 2'd2,
    MODE_READ_KEY   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_RANGE     = 3'd1,
    STATUS_DUPLICATE = 3'd2,
    STATUS_ORDER     = 3'd3,
    STATUS_NOT_FOUND = 3'd4,
    STATUS_NOT_READY = 3'd5
  } status_e;

  typedef struct packed {
    mode_e                mode;
    logic [IdxW-1:0]      index;
    logic [KeyW-1:0]      key;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [IdxW-1:0]      result_id;
    logic [KeyW-1:0]      result_key;
    logic                 found;
    logic                 mapping_ready;
  } rsp_t;

endpackage

@@ rtl/skl_apb_regs.sv @@
// APB register file holding the saturated document count.
module skl_apb_regs #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [skl_pkg::ApbAddrW-1:0]            paddr,
  input  logic [skl_pkg::ApbDataW-1:0]            pwdata,
  output logic [skl_pkg::ApbDataW-1:0]            prdata,
  output logic                                    pready,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]        doc_count_o,
  output logic                                    restart_o
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned VW = (CW > skl_pkg::DocCountW) ? CW : skl_pkg::DocCountW;

  logic [CW-1:0] doc_count_q, doc_count_d;
  logic [VW-1:0] wr_val;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == skl_pkg::RegDocCount);
  assign wr_val = VW'(pwdata[skl_pkg::DocCountW-1:0]);

  always_comb begin
    if (wr_val == '0) begin
      doc_count_d = CW'(1);
    end else if (wr_val > VW'(TABLE_DEPTH)) begin
      doc_count_d = CW'(TABLE_DEPTH);
    end else begin
      doc_count_d = CW'(wr_val);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      doc_count_q <= CW'(TABLE_DEPTH);
    end else if (wr_en) begin
      doc_count_q <= doc_count_d;
    end
  end

  assign prdata      = (paddr[2] == skl_pkg::RegDocCount) ? skl_pkg::ApbDataW'(doc_count_q) : '0;
  assign doc_count_o = doc_count_q;
  assign restart_o   = wr_en;

endmodule

@@ rtl/sorted_key_to_id_lookup.sv @@
// Sorted key to id lookup: key, order and position tables, load checks and binary search.
// A key read passes S_RD_KEY and an order load S_LD_POS and S_LD_ORD; a find takes at most
// ceil(log2(doc_count + 1)) probes, and each probe reads the order table and then the key
// table through one shared key comparator. One item at a time; busy drops as the beat
// appears, which the receiver cannot stall. Reset clears the control and load state, not
// the tables.
module sorted_key_to_id_lookup #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_BITS    = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  skl_pkg::req_t                 req_i,
  output logic                          done_o,
  output skl_pkg::rsp_t                 rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [skl_pkg::ApbAddrW-1:0]  paddr,
  input  logic [skl_pkg::ApbDataW-1:0]  pwdata,
  output logic [skl_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned XW = (CW > skl_pkg::IdxW) ? CW : skl_pkg::IdxW;
  localparam logic [KEY_BITS-1:0] KeyInv = '1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_RD_KEY = 7'b0000100,
    S_LD_POS = 7'b0001000,
    S_LD_ORD = 7'b0010000,
    S_SR_ORD = 7'b0100000,
    S_SR_KEY = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] doc_count;
  logic          restart;

  skl_apb_regs #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .doc_count_o(doc_count),
    .restart_o  (restart)
  );

  logic [KEY_BITS-1:0] key_mem [TABLE_DEPTH];
  logic [AW-1:0]       ord_mem [TABLE_DEPTH];
  logic [AW-1:0]       pos_mem [TABLE_DEPTH];

  skl_pkg::mode_e          mode_q;
  logic [skl_pkg::IdxW-1:0] idx_q;
  logic [KEY_BITS-1:0]     key_q;
  logic [KEY_BITS-1:0]     key_rd_q;
  logic [AW-1:0]           ord_rd_q, pos_rd_q;
  logic                    posv_q, posv_d;
  logic [CW-1:0]           lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0]           mid_q, mid_d;

  logic [CW-1:0]           lp_q, lp_d;
  logic [KEY_BITS-1:0]     prev_q, prev_d;
  logic                    have_q, have_d, inv_q, inv_d;
  logic                    ready_q, ready_d, failed_q, failed_d;

  logic                    done_q;
  skl_pkg::rsp_t           rsp_q, rsp_d;

  logic                    accept, idx_bad, seen, fin, fnd;
  logic                    cmp_lt, cmp_gt;
  logic [KEY_BITS-1:0]     cmp_b;
  skl_pkg::status_e        st;
  logic [AW-1:0]           rid;
  logic [skl_pkg::KeyW-1:0] rkey;
  logic                    key_we, key_re, ord_we, ord_re, pos_we, pos_re;
  logic [AW-1:0]           key_ra, ord_ra, pos_ra;

  assign busy    = (state_q != S_IDLE);
  assign accept  = start && !busy;
  assign idx_bad = XW'(idx_q) >= XW'(doc_count);
  assign seen    = posv_q && (ord_rd_q == AW'(idx_q));

  // One comparator serves both the load order check and the search probe.
  assign cmp_b  = (mode_q == skl_pkg::MODE_LOAD_ORDER) ? prev_q : key_q;
  assign cmp_lt = key_rd_q < cmp_b;
  assign cmp_gt = key_rd_q > cmp_b;

  always_comb begin
    state_d  = state_q;
    lp_d     = lp_q;
    prev_d   = prev_q;
    have_d   = have_q;
    inv_d    = inv_q;
    ready_d  = ready_q;
    failed_d = failed_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    posv_d   = posv_q;
    fin      = 1'b0;
    st       = skl_pkg::STATUS_OK;
    rid      = '0;
    rkey     = '0;
    fnd      = 1'b0;
    key_we   = 1'b0;
    key_re   = 1'b0;
    key_ra   = AW'(idx_q);
    ord_we   = 1'b0;
    ord_re   = 1'b0;
    ord_ra   = mid_q;
    pos_we   = 1'b0;
    pos_re   = 1'b0;
    pos_ra   = AW'(idx_q);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (mode_q)
          skl_pkg::MODE_WRITE_KEY: begin
            fin = 1'b1;
            if (idx_bad) begin
              st = skl_pkg::STATUS_RANGE;
            end else begin
              key_we   = 1'b1;
              lp_d     = '0;
              prev_d   = '0;
              have_d   = 1'b0;
              inv_d    = 1'b0;
              ready_d  = 1'b0;
              failed_d = 1'b0;
            end
          end
          skl_pkg::MODE_LOAD_ORDER: begin
            if (failed_q) begin
              fin = 1'b1;
              st  = skl_pkg::STATUS_NOT_READY;
            end else if (ready_q || (lp_q >= doc_count)) begin
              fin = 1'b1;
            end else if (idx_bad) begin
              fin      = 1'b1;
              st       = skl_pkg::STATUS_RANGE;
              failed_d = 1'b1;
            end else begin
              key_re  = 1'b1;
              pos_re  = 1'b1;
              state_d = S_LD_POS;
            end
          end
          skl_pkg::MODE_FIND: begin
            if (!ready_q) begin
              fin = 1'b1;
              st  = skl_pkg::STATUS_NOT_READY;
            end else if (key_q == KeyInv) begin
              fin = 1'b1;
              st  = skl_pkg::STATUS_NOT_FOUND;
            end else begin
              lo_d    = '0;
              hi_d    = doc_count;
              mid_d   = AW'(doc_count >> 1);
              ord_re  = 1'b1;
              ord_ra  = mid_d;
              state_d = S_SR_ORD;
            end
          end
          default: begin
            if (idx_bad) begin
              fin  = 1'b1;
              st   = skl_pkg::STATUS_RANGE;
              rkey = skl_pkg::KeyW'(KeyInv);
            end else begin
              key_re  = 1'b1;
              state_d = S_RD_KEY;
            end
          end
        endcase
      end
      S_RD_KEY: begin
        fin  = 1'b1;
        fnd  = 1'b1;
        rkey = skl_pkg::KeyW'(key_rd_q);
      end
      S_LD_POS: begin
        posv_d  = CW'(pos_rd_q) < lp_q;
        ord_re  = 1'b1;
        ord_ra  = pos_rd_q;
        state_d = S_LD_ORD;
      end
      S_LD_ORD: begin
        fin = 1'b1;
        if (seen) begin
          st       = skl_pkg::STATUS_DUPLICATE;
          failed_d = 1'b1;
        end else if ((key_rd_q != KeyInv) && (inv_q || (have_q && !cmp_gt))) begin
          st       = skl_pkg::STATUS_ORDER;
          failed_d = 1'b1;
        end else begin
          if (key_rd_q != KeyInv) begin
            prev_d = key_rd_q;
            have_d = 1'b1;
          end else begin
            inv_d = 1'b1;
          end
          ord_we  = 1'b1;
          pos_we  = 1'b1;
          lp_d    = lp_q + CW'(1);
          ready_d = (lp_d == doc_count);
        end
      end
      S_SR_ORD: begin
        if (CW'(ord_rd_q) >= doc_count) begin
          fin = 1'b1;
          st  = skl_pkg::STATUS_NOT_FOUND;
        end else begin
          key_re  = 1'b1;
          key_ra  = ord_rd_q;
          state_d = S_SR_KEY;
        end
      end
      S_SR_KEY: begin
        if (!cmp_lt && !cmp_gt) begin
          fin = 1'b1;
          fnd = 1'b1;
          rid = ord_rd_q;
        end else begin
          if (cmp_lt) begin
            lo_d = CW'(mid_q) + CW'(1);
          end else begin
            hi_d = CW'(mid_q);
          end
          if (lo_d < hi_d) begin
            mid_d   = AW'(lo_d + ((hi_d - lo_d) >> 1));
            ord_re  = 1'b1;
            ord_ra  = mid_d;
            state_d = S_SR_ORD;
          end else begin
            fin = 1'b1;
            st  = skl_pkg::STATUS_NOT_FOUND;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      state_d = S_IDLE;
    end

    if (restart) begin
      lp_d     = '0;
      prev_d   = '0;
      have_d   = 1'b0;
      inv_d    = 1'b0;
      ready_d  = 1'b0;
      failed_d = 1'b0;
    end

    rsp_d = rsp_q;
    if (fin) begin
      rsp_d.status        = st;
      rsp_d.result_id     = skl_pkg::IdxW'(rid);
      rsp_d.result_key    = rkey;
      rsp_d.found         = fnd;
      rsp_d.mapping_ready = ready_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      lp_q     <= '0;
      prev_q   <= '0;
      have_q   <= 1'b0;
      inv_q    <= 1'b0;
      ready_q  <= 1'b0;
      failed_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      lp_q     <= lp_d;
      prev_q   <= prev_d;
      have_q   <= have_d;
      inv_q    <= inv_d;
      ready_q  <= ready_d;
      failed_q <= failed_d;
      done_q   <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= req_i.mode;
      idx_q  <= req_i.index;
      key_q  <= KEY_BITS'(req_i.key);
    end
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    posv_q <= posv_d;
    rsp_q  <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[AW'(idx_q)] <= key_q;
    end
    if (key_re) begin
      key_rd_q <= key_mem[key_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[AW'(lp_q)] <= AW'(idx_q);
    end
    if (ord_re) begin
      ord_rd_q <= ord_mem[ord_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[AW'(idx_q)] <= AW'(lp_q);
    end
    if (pos_re) begin
      pos_rd_q <= pos_mem[pos_ra];
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q != S_IDLE))
    else $error("Result beat without an item in progress.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("Result beat lasted more than one cycle.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> (lp_q == doc_count))
    else $error("Mapping ready before every position was loaded.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ready_q && failed_q))
    else $error("Mapping both ready and rejected.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SR_ORD) |-> (lo_q < hi_q))
    else $error("Search probe issued on an empty range.");

endmodule
